### rtl/core/frac_pkg.sv
// Shared types and constants for the fraction arithmetic unit.
package frac_pkg;

    localparam int NUM_W = 33;
    localparam int DEN_W = 31;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } op_t;

    localparam logic [1:0] ORD_LESS  = 2'd0;
    localparam logic [1:0] ORD_EQUAL = 2'd1;
    localparam logic [1:0] ORD_GREAT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_COMB,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } state_t;

    // Start and finish of one restoring division run.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

### rtl/core/fraction_arithmetic_unit.sv
// Fraction arithmetic unit top level: sequencer, multiplier and shared divider.
//
// One item at a time. After an item is accepted, the block forms the products in
// the states MUL1, MUL2 and COMB with one shared multiplier. An arithmetic item is
// then reduced by the Euclidean GCD. Each remainder step is one run of a shared
// restoring divider. After the GCD, the block divides numerator and denominator by
// it with two more runs. A compare skips the GCD and the divider runs, and an error
// item goes straight to the output register. The result sits in an output register
// until it is taken, and in_stall stays high until then.
module fraction_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic signed [15:0] a_num,
    input  logic signed [15:0] a_den,
    input  logic signed [15:0] b_num,
    input  logic signed [15:0] b_den,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [32:0] result_num,
    output logic [30:0] result_den,
    output logic [1:0]  order,
    output logic        status
);

    localparam int OW = OPERAND_WIDTH;
    localparam int PW = 2 * OW;       // product magnitude width
    localparam int SW = PW + 1;       // sum magnitude width
    localparam int DW = SW + 1;       // divider width

    frac_pkg::state_t state_reg, state_next;

    logic [OW-1:0] an_m_reg, ad_m_reg, bn_m_reg, bd_m_reg;
    logic          an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic [2:0]    op_reg;
    logic [PW-1:0] p1_reg, p2_reg;   // an*bd (an*bn for MUL), bn*ad
    logic [SW-1:0] n_reg, d_reg;
    logic          neg_reg;
    logic [DW-1:0] gx_reg, gy_reg;
    logic signed [32:0] rnum_reg;
    logic [30:0]   rden_reg;
    logic [1:0]    ord_reg;
    logic          stat_reg;
    logic          ov_reg;

    logic [OW-1:0] mul_a, mul_b;
    logic [PW-1:0] mul_p;

    logic          div_start;
    logic [DW-1:0] div_x, div_y, div_q, div_r;
    frac_pkg::div_ctl_t div_ctl;

    logic in_acc, out_acc;
    logic signed [OW-1:0] an_i, ad_i, bn_i, bd_i;
    logic err_i;

    assign an_i = OW'($unsigned(a_num));
    assign ad_i = OW'($unsigned(a_den));
    assign bn_i = OW'($unsigned(b_num));
    assign bd_i = OW'($unsigned(b_den));
    assign err_i = (operation > 3'(frac_pkg::OP_CMP)) || (ad_i == '0) || (bd_i == '0)
                   || (operation == 3'(frac_pkg::OP_DIV) && bn_i == '0);

    assign in_stall = (state_reg != frac_pkg::ST_IDLE) || ov_reg;
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = ov_reg && !out_stall;

    // Shared multiplier on magnitudes.
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Signed sum/difference and compare helpers for the combine step.
    logic          s1, s2, s3, sb;
    logic          c1, c2;
    logic [SW-1:0] sum_m;
    logic          sum_s;
    logic          lt, eq;

    always_comb
    begin
        s1 = (an_s_reg ^ bd_s_reg) && (p1_reg != '0);
        s2 = (bn_s_reg ^ ad_s_reg) && (p2_reg != '0);
        s3 = ad_s_reg ^ bd_s_reg;
        sb = (op_reg == 3'(frac_pkg::OP_SUB)) ? !s2 && (p2_reg != '0) : s2;
        if (s1 == sb)
        begin
            sum_m = SW'(p1_reg) + SW'(p2_reg);
            sum_s = s1;
        end
        else if (p1_reg >= p2_reg)
        begin
            sum_m = SW'(p1_reg - p2_reg);
            sum_s = s1;
        end
        else
        begin
            sum_m = SW'(p2_reg - p1_reg);
            sum_s = sb;
        end
        // compare: sign of a is an^ad, sign of b is bn^bd after normalizing
        c1 = (an_s_reg ^ ad_s_reg) && (p1_reg != '0);
        c2 = (bn_s_reg ^ bd_s_reg) && (p2_reg != '0);
        if (c1 != c2)
        begin
            lt = c1;
            eq = 1'b0;
        end
        else
        begin
            eq = (p1_reg == p2_reg);
            lt = c1 ? (p1_reg > p2_reg) : (p1_reg < p2_reg);
        end
    end

    always_comb
    begin
        mul_a = an_m_reg;
        mul_b = bd_m_reg;
        case (state_reg)
            frac_pkg::ST_MUL1:
            begin
                mul_a = an_m_reg;
                mul_b = (op_reg == 3'(frac_pkg::OP_MUL)) ? bn_m_reg : bd_m_reg;
            end
            frac_pkg::ST_MUL2:
            begin
                mul_a = bn_m_reg;
                mul_b = ad_m_reg;
            end
            frac_pkg::ST_COMB:
            begin
                mul_a = ad_m_reg;
                mul_b = (op_reg == 3'(frac_pkg::OP_DIV)) ? bn_m_reg : bd_m_reg;
            end
            default:
            begin
                mul_a = an_m_reg;
                mul_b = bd_m_reg;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            frac_pkg::ST_IDLE:
                if (in_acc && !err_i)
                    state_next = frac_pkg::ST_MUL1;
            frac_pkg::ST_MUL1:
                state_next = frac_pkg::ST_MUL2;
            frac_pkg::ST_MUL2:
                state_next = frac_pkg::ST_COMB;
            frac_pkg::ST_COMB:
                state_next = (op_reg == 3'(frac_pkg::OP_CMP)) ? frac_pkg::ST_DONE
                                                            : frac_pkg::ST_GCD;
            frac_pkg::ST_GCD:
                if (!div_ctl.busy && !div_start && gy_reg == '0)
                    state_next = frac_pkg::ST_DIVN;
            frac_pkg::ST_DIVN:
                if (div_ctl.done)
                    state_next = frac_pkg::ST_DIVD;
            frac_pkg::ST_DIVD:
                if (div_ctl.done)
                    state_next = frac_pkg::ST_DONE;
            frac_pkg::ST_DONE:
                state_next = frac_pkg::ST_IDLE;
            default:
                state_next = frac_pkg::ST_IDLE;
        endcase
    end

    // Divider launch: one run per GCD step, then the two reductions.
    logic gcd_go_reg;
    always_comb
    begin
        div_start = 1'b0;
        div_x     = gx_reg;
        div_y     = gy_reg;
        case (state_reg)
            frac_pkg::ST_GCD:
                div_start = gcd_go_reg && (gy_reg != '0);
            frac_pkg::ST_DIVN:
            begin
                div_start = gcd_go_reg;
                div_x     = DW'(n_reg);
                div_y     = gx_reg;
            end
            frac_pkg::ST_DIVD:
            begin
                div_start = gcd_go_reg;
                div_x     = DW'(d_reg);
                div_y     = gx_reg;
            end
            default:
                div_start = 1'b0;
        endcase
    end

    frac_divider #(.W(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_x),
        .divisor   (div_y),
        .ctl       (div_ctl),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= frac_pkg::ST_IDLE;
            ov_reg     <= 1'b0;
            gcd_go_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_acc)
                ov_reg <= 1'b0;
            if ((in_acc && err_i) || state_reg == frac_pkg::ST_DONE)
                ov_reg <= 1'b1;
            // arm a divider run on entry to a state and after each GCD step
            gcd_go_reg <= (state_next != state_reg) || (state_reg == frac_pkg::ST_GCD
                          && div_ctl.done);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg   <= operation;
            an_s_reg <= an_i[OW-1];
            ad_s_reg <= ad_i[OW-1];
            bn_s_reg <= bn_i[OW-1];
            bd_s_reg <= bd_i[OW-1];
            an_m_reg <= an_i[OW-1] ? OW'(-an_i) : an_i;
            ad_m_reg <= ad_i[OW-1] ? OW'(-ad_i) : ad_i;
            bn_m_reg <= bn_i[OW-1] ? OW'(-bn_i) : bn_i;
            bd_m_reg <= bd_i[OW-1] ? OW'(-bd_i) : bd_i;
            if (err_i)
            begin
                rnum_reg <= '0;
                rden_reg <= '0;
                ord_reg  <= frac_pkg::ORD_LESS;
                stat_reg <= 1'b1;
            end
        end
        case (state_reg)
            frac_pkg::ST_MUL1:
                p1_reg <= mul_p;
            frac_pkg::ST_MUL2:
                p2_reg <= mul_p;
            frac_pkg::ST_COMB:
            begin
                stat_reg <= 1'b0;
                if (op_reg == 3'(frac_pkg::OP_CMP))
                begin
                    rnum_reg <= '0;
                    rden_reg <= '0;
                    ord_reg  <= eq ? frac_pkg::ORD_EQUAL
                              : (lt ? frac_pkg::ORD_LESS : frac_pkg::ORD_GREAT);
                end
                else
                begin
                    ord_reg <= frac_pkg::ORD_LESS;
                    if (op_reg == 3'(frac_pkg::OP_ADD) || op_reg == 3'(frac_pkg::OP_SUB))
                    begin
                        n_reg   <= sum_m;
                        neg_reg <= (sum_s != s3) && (sum_m != '0);
                        gx_reg  <= DW'(sum_m);
                    end
                    else
                    begin
                        n_reg   <= SW'(p1_reg);
                        neg_reg <= (op_reg == 3'(frac_pkg::OP_MUL))
                                   ? ((an_s_reg ^ bn_s_reg ^ s3) && p1_reg != '0)
                                   : ((an_s_reg ^ bd_s_reg ^ ad_s_reg ^ bn_s_reg)
                                      && p1_reg != '0);
                        gx_reg  <= DW'(p1_reg);
                    end
                    d_reg  <= SW'(mul_p);
                    gy_reg <= DW'(mul_p);
                end
            end
            frac_pkg::ST_GCD:
                if (div_ctl.done)
                begin
                    gx_reg <= gy_reg;
                    gy_reg <= div_r;
                end
            frac_pkg::ST_DIVN:
                if (div_ctl.done)
                    n_reg <= SW'(div_q);
            frac_pkg::ST_DIVD:
                if (div_ctl.done)
                begin
                    rden_reg <= 31'(div_q);
                    rnum_reg <= neg_reg ? 33'(-{1'b0, n_reg}) : 33'({1'b0, n_reg});
                end
            default:
                ;
        endcase
    end

    assign out_valid  = ov_reg;
    assign result_num = rnum_reg;
    assign result_den = rden_reg;
    assign order      = ord_reg;
    assign status     = stat_reg;

endmodule

### rtl/core/frac_divider.sv
// Restoring divider: one quotient bit per cycle, quotient and remainder.
module frac_divider #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output frac_pkg::div_ctl_t ctl,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb
    begin
        shifted   = {r_reg, q_reg[W-1]};
        trial     = shifted - {1'b0, d_reg};
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[W])
            begin
                r_next = shifted[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            else
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

### rtl/core/frac_checker.sv
// Port-level checks for the fraction arithmetic unit, bound to the top level.
module frac_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [30:0] result_den,
    input logic [1:0]  order,
    input logic        status
);

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("item accepted while one is in flight");

    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result waits");

    a_err_den: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (result_den == '0 && order == '0))
        else $error("error result carries data");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (order != 2'd3))
        else $error("bad order code");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result_den)))
        else $error("stalled result changed");

endmodule

bind fraction_arithmetic_unit frac_checker u_frac_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_den (result_den),
    .order      (order),
    .status     (status)
);

### sim/fraction_arithmetic_unit_tb.sv
// Testbench for the fraction arithmetic unit: random and directed items, scoreboard check.
module fraction_arithmetic_unit_tb;

    typedef struct {
        logic [2:0] op;
        logic signed [15:0] an, ad, bn, bd;
    } frac_item_t;

    typedef struct {
        logic signed [32:0] num;
        logic [30:0] den;
        logic [1:0] ord;
        logic stat;
    } frac_result_t;

    class frac_scoreboard;
        frac_result_t pending[$];
        int errors;

        function automatic longint unsigned gcd(longint unsigned x, longint unsigned y);
            longint unsigned t;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        function automatic frac_result_t reduce_fraction(frac_item_t it);
            frac_result_t r;
            longint an, ad, bn, bd, n, d, l, rr;
            longint unsigned g, nm, dm;
            an = it.an;
            ad = it.ad;
            bn = it.bn;
            bd = it.bd;
            r = '{num: '0, den: '0, ord: frac_pkg::ORD_LESS, stat: 1'b0};
            if (it.op > frac_pkg::OP_CMP || ad == 0 || bd == 0
                || (it.op == frac_pkg::OP_DIV && bn == 0))
            begin
                r.stat = 1'b1;
                return r;
            end
            if (it.op == frac_pkg::OP_CMP)
            begin
                if (ad < 0)
                begin
                    an = -an;
                    ad = -ad;
                end
                if (bd < 0)
                begin
                    bn = -bn;
                    bd = -bd;
                end
                l = an * bd;
                rr = bn * ad;
                r.ord = (l < rr) ? frac_pkg::ORD_LESS
                      : (l == rr) ? frac_pkg::ORD_EQUAL : frac_pkg::ORD_GREAT;
                return r;
            end
            case (it.op)
                frac_pkg::OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
                frac_pkg::OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
                frac_pkg::OP_MUL: begin n = an * bn; d = ad * bd; end
                default: begin n = an * bd; d = ad * bn; end
            endcase
            nm = (n < 0) ? -n : n;
            dm = (d < 0) ? -d : d;
            g = gcd(nm, dm);
            nm = nm / g;
            dm = dm / g;
            r.num = ((n < 0) != (d < 0) && nm != 0) ? 33'(-longint'(nm)) : 33'(nm);
            r.den = dm[30:0];
            return r;
        endfunction

        function void note_item(frac_item_t it);
            pending.push_back(reduce_fraction(it));
        endfunction

        task check_result(frac_result_t got);
            frac_result_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("result with no item pending");
                return;
            end
            want = pending.pop_front();
            if (got.num !== want.num)
                report_mismatch($sformatf("num got %0d want %0d", got.num, want.num));
            if (got.den !== want.den)
                report_mismatch($sformatf("den got %0d want %0d", got.den, want.den));
            if (got.ord !== want.ord)
                report_mismatch($sformatf("order got %0d want %0d", got.ord, want.ord));
            if (got.stat !== want.stat)
                report_mismatch($sformatf("status got %0d want %0d", got.stat, want.stat));
        endtask

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] operation = '0;
    logic signed [15:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [32:0] result_num;
    logic [30:0] result_den;
    logic [1:0] order;
    logic status;

    frac_scoreboard board = new();
    int cycle_count = 0;
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    bit hold_off = 1'b0;

    fraction_arithmetic_unit dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .a_num(a_num), .a_den(a_den), .b_num(b_num),
        .b_den(b_den), .out_valid(out_valid), .out_stall(out_stall),
        .result_num(result_num), .result_den(result_den), .order(order),
        .status(status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 20000000)
        begin
            $display("FAIL fraction_arithmetic_unit");
            $finish;
        end
    end

    // Accept on the rising edge; note items and check results there.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_item('{op: operation, an: a_num, ad: a_den, bn: b_num, bd: b_den});
        if (rst_n && out_valid && !out_stall)
            board.check_result('{num: result_num, den: result_den, ord: order,
                                 stat: status});
    end

    // Receiver: random stall, held high through a hold-off.
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= recv_idle_on && ($urandom_range(99) < 28);
    end

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd0;
            3: return $urandom_range(1) ? 16'sd1 : -16'sd1;
            4, 5: return $signed(16'($urandom_range(40))) - 16'sd20;
            default: return 16'($urandom);
        endcase
    endfunction

    // Drop valid only while idling, so each falling edge drives it at most once.
    task send_item(frac_item_t it);
        while (send_idle_on && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= it.op;
        a_num <= it.an;
        a_den <= it.ad;
        b_num <= it.bn;
        b_den <= it.bd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task send_random(int count);
        frac_item_t it;
        repeat (count)
        begin
            it.op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                              : 3'($urandom_range(4));
            it.an = pick_value();
            it.ad = pick_value();
            it.bn = pick_value();
            it.bd = pick_value();
            // Keep denominators mostly nonzero so arithmetic paths dominate.
            if (it.ad == 0 && $urandom_range(3) != 0)
                it.ad = 16'sd7;
            if (it.bd == 0 && $urandom_range(3) != 0)
                it.bd = -16'sd3;
            send_item(it);
        end
    endtask

    task wait_drained();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        frac_item_t dir[$];
        dir.push_back('{frac_pkg::OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3});
        dir.push_back('{frac_pkg::OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2});
        dir.push_back('{frac_pkg::OP_MUL, -16'sd4, 16'sd6, 16'sd3, -16'sd8});
        dir.push_back('{frac_pkg::OP_DIV, 16'sd3, 16'sd4, -16'sd9, 16'sd8});
        dir.push_back('{frac_pkg::OP_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd8});
        dir.push_back('{frac_pkg::OP_CMP, 16'sd1, 16'sd3, 16'sd1, 16'sd2});
        dir.push_back('{frac_pkg::OP_CMP, 16'sd2, -16'sd4, -16'sd1, 16'sd2});
        dir.push_back('{frac_pkg::OP_CMP, 16'sd5, 16'sd1, 16'sd1, -16'sd1});
        dir.push_back('{frac_pkg::OP_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1});
        dir.push_back('{frac_pkg::OP_MUL, 16'sd1, 16'sd1, 16'sd1, 16'sd0});
        dir.push_back('{3'd5, 16'sd1, 16'sd1, 16'sd1, 16'sd1});
        dir.push_back('{3'd7, 16'sd1, 16'sd1, 16'sd1, 16'sd1});
        dir.push_back('{frac_pkg::OP_ADD, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
        dir.push_back('{frac_pkg::OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
        dir.push_back('{frac_pkg::OP_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1});
        dir.push_back('{frac_pkg::OP_DIV, 16'sh8000, 16'sh7fff, 16'sd1, 16'sh8000});
        dir.push_back('{frac_pkg::OP_CMP, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
        dir.push_back('{frac_pkg::OP_MUL, 16'sd0, -16'sd5, 16'sd3, 16'sd7});
        dir.push_back('{frac_pkg::OP_ADD, 16'shffff, 16'shffff, 16'sh5555, 16'shaaaa});
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (dir[i])
            send_item(dir[i]);
        send_random(300);
        // Hold the receiver off while the sender keeps offering items.
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(negedge clk);
                hold_off = 1'b0;
            end
            send_random(20);
        join
        // Pause the sender until every result is back.
        wait_drained();
        send_random(300);
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        send_random(200);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        send_random(310);
        wait_drained();
        repeat (200) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS fraction_arithmetic_unit");
        else
            $display("FAIL fraction_arithmetic_unit");
        $finish;
    end
endmodule
